[rtl/pci_pkg.sv]
// ----------------------------------------------------------------------------
// pci_pkg
// Shared widths, types and command/status bundles of the polygon corner
// intersector.
// ----------------------------------------------------------------------------
`default_nettype none

package pci_pkg;

  // Field widths
  localparam int unsigned CoordW   = 12;
  localparam int unsigned OutW     = 24;
  localparam int unsigned FracBits = 8;
  localparam int unsigned DefSides = 8;

  // Datapath widths, sized for 12-bit unsigned endpoints
  localparam int unsigned DiffW     = CoordW + 1;                // endpoint difference
  localparam int unsigned CrossW    = 2 * DiffW;                 // cross product, signed
  localparam int unsigned CrossMagW = CrossW - 1;                // |cross product|
  localparam int unsigned ProdW     = DiffW + CrossW - 1;        // d1 * numerator, signed
  localparam int unsigned MagW      = ProdW - 1;                 // |d1 * numerator|
  localparam int unsigned DvdW      = MagW + FracBits + 2;       // 2|n| + |d|
  localparam int unsigned DsrW      = CrossMagW + 1;             // 2|d|
  localparam int unsigned SumW      = DvdW + 2;                  // base + signed quotient
  localparam int unsigned DivSteps  = DvdW;                      // one quotient bit a step
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  typedef struct packed {
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x0;
  } line_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_CHECK,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // take the input line
    logic first_side;  // input line opens a polygon
    logic pair1;       // load current line against first line
    logic form_cross;  // form cross products
    logic scale;       // form scaled numerators
    logic prep;        // set up the divider
    logic step;        // one divider step
    logic load_out;    // load the output register
    logic abort;       // result is a parallel abort
    logic last_out;    // result closes the polygon
  } pci_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic parallel;
  } pci_sts_t;

endpackage

`default_nettype wire

[rtl/pci_line_if.sv]
// ----------------------------------------------------------------------------
// pci_line_if
// Input channel: one polygon edge line per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pci_line_if import pci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] start_x;
  logic [CoordW-1:0] start_y;
  logic [CoordW-1:0] end_x;
  logic [CoordW-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

`default_nettype wire

[rtl/pci_corner_if.sv]
// ----------------------------------------------------------------------------
// pci_corner_if
// Output channel: one corner or abort result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pci_corner_if import pci_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] corner_x;
  logic signed [OutW-1:0] corner_y;
  logic                   status;
  logic                   final_corner;

  modport source (output valid, output corner_x, output corner_y, output status,
                  output final_corner, input ready);
  modport sink   (input valid, input corner_x, input corner_y, input status,
                  input final_corner, output ready);
endinterface

`default_nettype wire

[rtl/pci_ctrl.sv]
// ----------------------------------------------------------------------------
// pci_ctrl
// Sequencer: side counting, abort tracking, divider step count and the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_ctrl import pci_pkg::*; #(
  parameter int unsigned SIDES = DefSides
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  pci_sts_t sts_i,
  output pci_cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(SIDES);

  state_e             state_q, state_d;
  logic [CntW-1:0]    side_q, side_d;
  logic               aborted_q, aborted_d;
  logic               last_q, last_d;
  logic               pass_q, pass_d;
  logic               abort_q, abort_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;
  logic               side_last;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= '0;
      aborted_q   <= 1'b0;
      last_q      <= 1'b0;
      pass_q      <= 1'b0;
      abort_q     <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      aborted_q   <= aborted_d;
      last_q      <= last_d;
      pass_q      <= pass_d;
      abort_q     <= abort_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign slot_free   = !out_valid_q || out_ready_i;
  assign side_last   = (side_q == CntW'(SIDES - 1));
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    side_d      = side_q;
    aborted_d   = aborted_q;
    last_d      = last_q;
    pass_d      = pass_q;
    abort_d     = abort_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept     = 1'b1;
          cmd_o.first_side = (side_q == '0);
          side_d           = side_last ? '0 : side_q + 1'b1;
          last_d           = side_last;
          pass_d           = 1'b0;
          abort_d          = 1'b0;
          if (side_q == '0) begin
            aborted_d = 1'b0;
          end else if (!aborted_q) begin
            state_d = ST_CROSS;
          end
        end
      end
      ST_CROSS: begin
        cmd_o.form_cross = 1'b1;
        state_d          = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.parallel) begin
          // Drop the rest of this polygon
          abort_d   = 1'b1;
          aborted_d = 1'b1;
          state_d   = ST_EMIT;
        end else begin
          cmd_o.scale = 1'b1;
          state_d     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        div_cnt_d  = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        div_cnt_d  = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.abort    = abort_q;
          cmd_o.last_out = abort_q || pass_q;
          out_valid_d    = 1'b1;
          if (!abort_q && !pass_q && last_q) begin
            // Closing corner against the first line
            cmd_o.pair1 = 1'b1;
            pass_d      = 1'b1;
            state_d     = ST_CROSS;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/pci_dp.sv]
// ----------------------------------------------------------------------------
// pci_dp
// Datapath: line storage, cross products, two-lane restoring divider sharing
// one divisor, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_dp import pci_pkg::*; (
  input  logic                   clk_i,
  input  line_t                  line_i,
  input  pci_cmd_t               cmd_i,
  output pci_sts_t               sts_o,
  output logic signed [OutW-1:0] corner_x_o,
  output logic signed [OutW-1:0] corner_y_o,
  output logic                   status_o,
  output logic                   final_corner_o
);

  localparam logic signed [SumW-1:0] SumMax = SumW'((2 ** (OutW - 1)) - 1);
  localparam logic signed [SumW-1:0] SumMin = -SumW'(2 ** (OutW - 1));

  line_t cur_q, first_q, prior_q, a_q, b_q;

  logic signed [CrossW-1:0] cr_q, num_q;
  logic signed [ProdW-1:0]  nx_q, ny_q;
  logic [DsrW-1:0]          dsr_q;
  logic [DvdW-1:0]          dvdx_q, dvdy_q;
  logic [DsrW-1:0]          remx_q, remy_q;
  logic                     negx_q, negy_q;

  logic signed [OutW-1:0] corner_x_q, corner_y_q;
  logic                   status_q, final_q;

  logic signed [DiffW-1:0] d1x, d1y, d2x, d2y, xx, xy;
  logic [CrossMagW-1:0]    abs_cr;
  logic [DsrW:0]           remx_sh, remy_sh;
  logic                    gex, gey;
  logic signed [OutW-1:0]  cx, cy;

  // Zero-extended difference of two coordinates
  function automatic logic signed [DiffW-1:0] diff(input logic [CoordW-1:0] hi,
                                                   input logic [CoordW-1:0] lo);
    return $signed({1'b0, hi}) - $signed({1'b0, lo});
  endfunction

  // Magnitude of the scaled numerator, times two, plus |d| for rounding
  function automatic logic [DvdW-1:0] dividend(input logic signed [ProdW-1:0] n,
                                               input logic [CrossMagW-1:0] d);
    logic [ProdW-1:0] mag;
    mag = n[ProdW-1] ? -n : n;
    return {mag[MagW-1:0], {(FracBits + 1){1'b0}}} + DvdW'(d);
  endfunction

  // Add the base coordinate to the signed quotient and clamp to Q15.8
  function automatic logic signed [OutW-1:0] corner(input logic [CoordW-1:0] base,
                                                    input logic [DvdW-1:0] q,
                                                    input logic neg);
    logic signed [SumW-1:0] qs;
    logic signed [SumW-1:0] sum;
    qs  = neg ? -$signed(SumW'(q)) : $signed(SumW'(q));
    sum = $signed(SumW'({base, {FracBits{1'b0}}})) + qs;
    if (sum > SumMax) begin
      return SumMax[OutW-1:0];
    end else if (sum < SumMin) begin
      return SumMin[OutW-1:0];
    end
    return sum[OutW-1:0];
  endfunction

  // Directions and offset of the current pair
  assign d1x = diff(a_q.x1, a_q.x0);
  assign d1y = diff(a_q.y1, a_q.y0);
  assign d2x = diff(b_q.x1, b_q.x0);
  assign d2y = diff(b_q.y1, b_q.y0);
  assign xx  = diff(b_q.x0, a_q.x0);
  assign xy  = diff(b_q.y0, a_q.y0);

  assign abs_cr = cr_q[CrossW-1] ? CrossMagW'(-cr_q) : cr_q[CrossMagW-1:0];

  // Divider step compare
  assign remx_sh = {remx_q, dvdx_q[DvdW-1]};
  assign remy_sh = {remy_q, dvdy_q[DvdW-1]};
  assign gex     = (remx_sh >= {1'b0, dsr_q});
  assign gey     = (remy_sh >= {1'b0, dsr_q});

  assign cx = corner(a_q.x0, dvdx_q, negx_q);
  assign cy = corner(a_q.y0, dvdy_q, negy_q);

  assign sts_o.parallel = (cr_q == '0);

  // Line storage and pair selection
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q   <= line_i;
      prior_q <= line_i;
      a_q     <= prior_q;
      b_q     <= line_i;
      if (cmd_i.first_side) begin
        first_q <= line_i;
      end
    end else if (cmd_i.pair1) begin
      a_q <= cur_q;
      b_q <= first_q;
    end
  end

  // Cross products and scaled numerators
  always_ff @(posedge clk_i) begin
    if (cmd_i.form_cross) begin
      cr_q  <= d1x * d2y - d1y * d2x;
      num_q <= xx * d2y - xy * d2x;
    end
    if (cmd_i.scale) begin
      nx_q <= d1x * num_q;
      ny_q <= d1y * num_q;
    end
  end

  // Divider setup and steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dsr_q  <= {abs_cr, 1'b0};
      dvdx_q <= dividend(nx_q, abs_cr);
      dvdy_q <= dividend(ny_q, abs_cr);
      remx_q <= '0;
      remy_q <= '0;
      negx_q <= nx_q[ProdW-1] ^ cr_q[CrossW-1];
      negy_q <= ny_q[ProdW-1] ^ cr_q[CrossW-1];
    end else if (cmd_i.step) begin
      remx_q <= gex ? DsrW'(remx_sh - {1'b0, dsr_q}) : remx_sh[DsrW-1:0];
      remy_q <= gey ? DsrW'(remy_sh - {1'b0, dsr_q}) : remy_sh[DsrW-1:0];
      dvdx_q <= {dvdx_q[DvdW-2:0], gex};
      dvdy_q <= {dvdy_q[DvdW-2:0], gey};
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      corner_x_q <= cmd_i.abort ? '0 : cx;
      corner_y_q <= cmd_i.abort ? '0 : cy;
      status_q   <= cmd_i.abort;
      final_q    <= cmd_i.last_out;
    end
  end

  assign corner_x_o     = corner_x_q;
  assign corner_y_o     = corner_y_q;
  assign status_o       = status_q;
  assign final_corner_o = final_q;

endmodule

`default_nettype wire

[rtl/polygon_corner_intersector_top.sv]
// ----------------------------------------------------------------------------
// polygon_corner_intersector_top
// Intersects each polygon edge line with the previous one and closes the
// polygon against its first line, giving Q15.8 corners.
// ----------------------------------------------------------------------------
// One line is taken per transaction; SIDES lines make a polygon. A line that
// gives no result (first side, or a side after an abort) is only stored. A
// side giving a corner passes accept, cross products, scaling, divider setup,
// 47 steps of the bit-serial restoring divider, and the load of the output
// register; the last side then runs again from the cross products for the
// closing corner. A parallel pair skips the divider for its abort result. The
// divider, one quotient bit per cycle for x and y side by side, sets the item
// time. The output register lets the next line be taken while a result waits.
`default_nettype none

module polygon_corner_intersector_top import pci_pkg::*; #(
  parameter int unsigned SIDES = DefSides
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pci_line_if.sink     line_i,
  pci_corner_if.source corner_o
);

  pci_cmd_t cmd;
  pci_sts_t sts;
  line_t    line_in;

  assign line_in.x0 = line_i.start_x;
  assign line_in.y0 = line_i.start_y;
  assign line_in.x1 = line_i.end_x;
  assign line_in.y1 = line_i.end_y;

  // Sequencer
  pci_ctrl #(
    .SIDES (SIDES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (line_i.valid),
    .in_ready_o  (line_i.ready),
    .out_ready_i (corner_o.ready),
    .out_valid_o (corner_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and result register
  pci_dp u_dp (
    .clk_i          (clk_i),
    .line_i         (line_in),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .corner_x_o     (corner_o.corner_x),
    .corner_y_o     (corner_o.corner_y),
    .status_o       (corner_o.status),
    .final_corner_o (corner_o.final_corner)
  );

endmodule

`default_nettype wire
